>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hw/rtl/mpd_pkg.sv
`default_nettype none

package mpd_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 63;

  localparam logic [29:0] PRIME     = 30'd998244353;
  localparam logic [29:0] INV_EXP   = 30'd998244351;
  // 2^30 mod PRIME
  localparam logic [29:0] FOLD      = 30'd75497471;
  localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'd998244353);
  localparam logic [31:0] PRIME_W   = {2'b00, PRIME};
  localparam logic [31:0] PRIME_2W  = {1'b0, PRIME, 1'b0};

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE_HI,
    S_BASE_LO,
    S_DIV_HI,
    S_DIV_LO,
    S_LOOP,
    S_SQR,
    S_FINAL,
    S_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    SEL_BASE_HI,
    SEL_BASE_LO,
    SEL_DIV_HI,
    SEL_DIV_LO,
    SEL_MUL,
    SEL_SQR,
    SEL_FINAL
  } sel_t;

  typedef enum logic [1:0] {
    DST_TMP,
    DST_BASE,
    DST_X,
    DST_ACC
  } dest_t;

  typedef struct packed {
    logic  load;
    logic  issue;
    sel_t  sel;
    dest_t dest;
    logic  shift_e;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic e_zero;
    logic e_lsb;
    logic pipe_idle;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/modular_power_and_divide.sv
// Channel   Handshake              Payload
// command   start, busy            op, base, second_operand
// result    done (one-cycle pulse) residue
//
// A command is taken at a clock edge with start high and busy low; busy stays
// high until the result pulse has gone by. Each modular multiply passes a
// four-stage Barrett pipeline, drained before the next step, but a loop
// multiply and its square go in back to back. Reset (synchronous) returns
// the controller to idle and clears the pipeline. done pulses for one cycle
// and cannot be held; residue keeps the result until the next command.
`default_nettype none
`include "assert_macros.svh"

module modular_power_and_divide #(
  parameter int unsigned OPERAND_BITS = mpd_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    op,
  input  logic [OPERAND_BITS-1:0] base,
  input  logic [OPERAND_BITS-1:0] second_operand,
  output logic                    busy,
  output logic                    done,
  output logic [29:0]             residue
);
  import mpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  mpd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mpd_datapath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (op),
    .base          (base),
    .second_operand(second_operand),
    .status        (status),
    .residue       (residue)
  );

  `ASSERT_SAME(a_residue_range, done, residue < PRIME, "residue not reduced")
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `ASSERT_NEXT(a_done_release, done, !busy && !done, "result pulse not single")
  `ASSERT_SAME(a_done_pipe_idle, done, status.pipe_idle, "result before pipeline drained")

endmodule

`default_nettype wire

>>> hw/rtl/mpd_mulmod.sv
`default_nettype none

module mpd_mulmod (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [29:0]    a,
  input  logic [29:0]    b,
  input  logic [29:0]    c,
  input  mpd_pkg::dest_t in_dest,
  output logic           out_valid,
  output logic [29:0]    result,
  output mpd_pkg::dest_t out_dest,
  output logic           idle
);
  import mpd_pkg::*;

  logic [59:0] ab;
  logic [31:0] qlow;
  logic [31:0] r_sub1;
  logic [31:0] r_sub2;

  logic        v1, v2, v3, v4;
  dest_t       d1, d2, d3, d4;
  logic [59:0] prod1;
  logic [61:0] t2;
  logic [31:0] x2, x3;
  logic [31:0] qp3;
  logic [31:0] r4;

  assign ab   = 60'(a) * 60'(b);
  assign qlow = 32'(t2[61:31]) * PRIME_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    d1    <= in_dest;
    prod1 <= ab + 60'(c);
    d2    <= d1;
    t2    <= 62'(prod1[59:29]) * 62'(BARRETT_M);
    x2    <= prod1[31:0];
    d3    <= d2;
    qp3   <= qlow;
    x3    <= x2;
    d4    <= d3;
    r4    <= x3 - qp3;
  end

  // Barrett remainder is below three times the modulus
  assign r_sub1 = r4 - PRIME_W;
  assign r_sub2 = r4 - PRIME_2W;

  always_comb begin
    if (r4 >= PRIME_2W) begin
      result = r_sub2[29:0];
    end else if (r4 >= PRIME_W) begin
      result = r_sub1[29:0];
    end else begin
      result = r4[29:0];
    end
  end

  assign out_valid = v4;
  assign out_dest  = d4;
  assign idle      = !(v1 || v2 || v3 || v4);

endmodule

`default_nettype wire

>>> hw/rtl/mpd_datapath.sv
`default_nettype none

module mpd_datapath #(
  parameter int unsigned OPERAND_BITS = mpd_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mpd_pkg::cmd_t           cmd,
  input  logic                    op,
  input  logic [OPERAND_BITS-1:0] base,
  input  logic [OPERAND_BITS-1:0] second_operand,
  output mpd_pkg::status_t        status,
  output logic [29:0]             residue
);
  import mpd_pkg::*;

  logic                    op_q;
  logic [OPERAND_BITS-1:0] base_q;
  logic [OPERAND_BITS-1:0] sec_q;
  logic [OPERAND_BITS-1:0] e;
  logic [29:0]             tmp;
  logic [29:0]             br;
  logic [29:0]             x;
  logic [29:0]             acc;

  logic [63:0] base_ext;
  logic [63:0] sec_ext;
  logic [29:0] mm_a, mm_b, mm_c;
  logic        mm_valid;
  logic [29:0] mm_result;
  dest_t       mm_dest;
  logic        mm_idle;

  assign base_ext = 64'(base_q);
  assign sec_ext  = 64'(sec_q);

  always_comb begin
    case (cmd.sel)
      SEL_BASE_HI: begin
        mm_a = 30'(base_ext[63:60]);
        mm_b = FOLD;
        mm_c = base_ext[59:30];
      end
      SEL_BASE_LO: begin
        mm_a = tmp;
        mm_b = FOLD;
        mm_c = base_ext[29:0];
      end
      SEL_DIV_HI: begin
        mm_a = 30'(sec_ext[63:60]);
        mm_b = FOLD;
        mm_c = sec_ext[59:30];
      end
      SEL_DIV_LO: begin
        mm_a = tmp;
        mm_b = FOLD;
        mm_c = sec_ext[29:0];
      end
      SEL_MUL: begin
        mm_a = acc;
        mm_b = x;
        mm_c = '0;
      end
      SEL_SQR: begin
        mm_a = x;
        mm_b = x;
        mm_c = '0;
      end
      SEL_FINAL: begin
        mm_a = br;
        mm_b = acc;
        mm_c = '0;
      end
      default: begin
        mm_a = '0;
        mm_b = '0;
        mm_c = '0;
      end
    endcase
  end

  mpd_mulmod u_mulmod (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.issue),
    .a        (mm_a),
    .b        (mm_b),
    .c        (mm_c),
    .in_dest  (cmd.dest),
    .out_valid(mm_valid),
    .result   (mm_result),
    .out_dest (mm_dest),
    .idle     (mm_idle)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      base_q <= base;
      sec_q  <= second_operand;
      e      <= op ? OPERAND_BITS'(INV_EXP) : second_operand;
      acc    <= 30'd1;
    end else begin
      if (cmd.shift_e) begin
        e <= e >> 1;
      end
      if (mm_valid) begin
        case (mm_dest)
          DST_TMP:  tmp <= mm_result;
          DST_BASE: begin
            br <= mm_result;
            x  <= mm_result;
          end
          DST_X:    x   <= mm_result;
          DST_ACC:  acc <= mm_result;
          default:  tmp <= mm_result;
        endcase
      end
    end
  end

  assign status.op        = op_q;
  assign status.e_zero    = (e == '0);
  assign status.e_lsb     = e[0];
  assign status.pipe_idle = mm_idle;
  assign residue          = acc;

endmodule

`default_nettype wire

>>> hw/rtl/mpd_ctrl.sv
`default_nettype none

module mpd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mpd_pkg::status_t status,
  output mpd_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import mpd_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_BASE_HI;
        end
      end
      S_BASE_HI: begin
        state_next = S_WAIT;
        ret_next   = S_BASE_LO;
      end
      S_BASE_LO: begin
        state_next = S_WAIT;
        ret_next   = status.op ? S_DIV_HI : S_LOOP;
      end
      S_DIV_HI: begin
        state_next = S_WAIT;
        ret_next   = S_DIV_LO;
      end
      S_DIV_LO: begin
        state_next = S_WAIT;
        ret_next   = S_LOOP;
      end
      S_LOOP: begin
        if (status.e_zero) begin
          state_next = status.op ? S_FINAL : S_DONE;
        end else begin
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        state_next = S_WAIT;
        ret_next   = S_LOOP;
      end
      S_FINAL: begin
        state_next = S_WAIT;
        ret_next   = S_DONE;
      end
      S_WAIT: begin
        if (status.pipe_idle) begin
          state_next = ret;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = SEL_MUL;
    cmd.dest = DST_ACC;
    busy     = 1'b1;
    done     = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_BASE_HI: begin
        cmd.issue = 1'b1;
        cmd.sel   = SEL_BASE_HI;
        cmd.dest  = DST_TMP;
      end
      S_BASE_LO: begin
        cmd.issue = 1'b1;
        cmd.sel   = SEL_BASE_LO;
        cmd.dest  = DST_BASE;
      end
      S_DIV_HI: begin
        cmd.issue = 1'b1;
        cmd.sel   = SEL_DIV_HI;
        cmd.dest  = DST_TMP;
      end
      S_DIV_LO: begin
        cmd.issue = 1'b1;
        cmd.sel   = SEL_DIV_LO;
        cmd.dest  = DST_X;
      end
      S_LOOP: begin
        cmd.issue = !status.e_zero && status.e_lsb;
        cmd.sel   = SEL_MUL;
        cmd.dest  = DST_ACC;
      end
      S_SQR: begin
        cmd.issue   = 1'b1;
        cmd.sel     = SEL_SQR;
        cmd.dest    = DST_X;
        cmd.shift_e = 1'b1;
      end
      S_FINAL: begin
        cmd.issue = 1'b1;
        cmd.sel   = SEL_FINAL;
        cmd.dest  = DST_ACC;
      end
      S_WAIT: begin
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> test/modular_power_and_divide_tb.sv
`timescale 1ns / 100ps

module modular_power_and_divide_tb;

  localparam int unsigned OB = mpd_pkg::OPERAND_BITS_DEF;
  localparam logic [63:0] MOD = 64'(mpd_pkg::PRIME);
  localparam logic [62:0] MAX_OPERAND = '1;
  localparam logic [62:0] TOP_MULTIPLE = 63'((64'(MAX_OPERAND) / MOD) * MOD);
  localparam logic OP_POWER = 1'b0;
  localparam logic OP_DIVIDE = 1'b1;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned TAIL_CYCLES = 600;

  typedef struct {
    logic        op;
    logic [62:0] base;
    logic [62:0] second_operand;
  } command_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          op;
  logic [OB-1:0] base;
  logic [OB-1:0] second_operand;
  logic          busy;
  logic          done;
  logic [29:0]   residue;

  command_t    command_queue[$];
  logic [29:0] pending_residues[$];
  command_t    taken_cmd;
  logic [29:0] want_residue;
  int unsigned error_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned idle_cycles;

  modular_power_and_divide #(
    .OPERAND_BITS(OB)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(op),
    .base(base),
    .second_operand(second_operand),
    .busy(busy),
    .done(done),
    .residue(residue)
  );

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b);
    return ((a % MOD) * (b % MOD)) % MOD;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] x, logic [63:0] e);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq = x % MOD;
    for (int i = 0; i < 64; i++) begin
      if (e[i]) begin
        acc = mul_mod(acc, sq);
      end
      sq = mul_mod(sq, sq);
    end
    return acc;
  endfunction

  function automatic logic [29:0] expected_residue(command_t c);
    logic [63:0] r;
    if (c.op == OP_POWER) begin
      r = pow_mod(64'(c.base), 64'(c.second_operand));
    end else begin
      r = mul_mod(64'(c.base), pow_mod(64'(c.second_operand), MOD - 64'd2));
    end
    return r[29:0];
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [62:0] rand_multiple();
    return 63'(MOD * 64'($urandom));
  endfunction

  function automatic command_t make_cmd(logic o, logic [62:0] a, logic [62:0] b);
    command_t c;
    c.op = o;
    c.base = a;
    c.second_operand = b;
    return c;
  endfunction

  task automatic add_command(command_t c);
    command_queue.insert(command_queue.size(), c);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: hold the front transaction until the block takes it
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (command_queue.size() > 0) begin
      start <= 1'b1;
      op <= command_queue[0].op;
      base <= command_queue[0].base;
      second_operand <= command_queue[0].second_operand;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on each accepted transaction, check each result
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        taken_cmd = command_queue.pop_front();
        pending_residues.insert(pending_residues.size(), expected_residue(taken_cmd));
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 6);
            gap_left = $urandom_range(0, 20);
          end
        end
      end
      if (done) begin
        if (pending_residues.size() == 0) begin
          $display("%0t: unexpected residue: expected none, actual %0d", $time, residue);
          error_count++;
        end else begin
          want_residue = pending_residues.pop_front();
          if (residue !== want_residue) begin
            $display("%0t: residue mismatch: expected %0d, actual %0d",
                     $time, want_residue, residue);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d transactions unsent, %0d residues outstanding",
               $time, command_queue.size(), pending_residues.size());
      $display("FAIL modular_power_and_divide");
      $finish;
    end
  end

  initial begin
    logic        o;
    logic [62:0] a;
    logic [62:0] b;
    int unsigned k;
    rst = 1'b1;
    start = 1'b0;
    op = 1'b0;
    base = '0;
    second_operand = '0;
    error_count = 0;
    burst_left = 4;
    gap_left = 0;
    idle_cycles = 0;

    add_command(make_cmd(OP_POWER, 63'd0, 63'd0));
    add_command(make_cmd(OP_POWER, 63'(MOD), 63'd0));
    add_command(make_cmd(OP_POWER, MAX_OPERAND, 63'd0));
    add_command(make_cmd(OP_POWER, MAX_OPERAND, MAX_OPERAND));
    add_command(make_cmd(OP_POWER, 63'd0, 63'd5));
    add_command(make_cmd(OP_POWER, TOP_MULTIPLE, 63'd3));
    add_command(make_cmd(OP_POWER, 63'd2, 63'h4000_0000_0000_0000));
    add_command(make_cmd(OP_POWER, 63'(MOD - 1), 63'd2));
    add_command(make_cmd(OP_POWER, 63'd7, 63'(MOD - 1)));
    add_command(make_cmd(OP_POWER, 63'(MOD + 1), MAX_OPERAND));
    add_command(make_cmd(OP_POWER, MAX_OPERAND, 63'd1));
    add_command(make_cmd(OP_DIVIDE, 63'd5, 63'd0));
    add_command(make_cmd(OP_DIVIDE, 63'd5, 63'(MOD)));
    add_command(make_cmd(OP_DIVIDE, 63'd9, TOP_MULTIPLE));
    add_command(make_cmd(OP_DIVIDE, MAX_OPERAND, MAX_OPERAND));
    add_command(make_cmd(OP_DIVIDE, 63'd0, 63'd7));
    add_command(make_cmd(OP_DIVIDE, 63'(MOD - 1), 63'(MOD - 1)));
    add_command(make_cmd(OP_DIVIDE, 63'd1, 63'd2));
    add_command(make_cmd(OP_DIVIDE, 63'd3, 63'(MOD + 1)));
    add_command(make_cmd(OP_DIVIDE, 63'(MOD), MAX_OPERAND));

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // drain before the random part
    while (command_queue.size() > 0 || pending_residues.size() > 0) @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        while (command_queue.size() > 0 || pending_residues.size() > 0) @(negedge clk);
      end
      o = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: a = 63'd0;
        1: a = rand_multiple();
        2: a = 63'(MOD - 1);
        3: a = 63'($urandom_range(0, 100));
        default: a = rand63();
      endcase
      if (o == OP_POWER) begin
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(0, 12);
        end else begin
          k = $urandom_range(13, 63);
        end
        b = rand63() & 63'((64'd1 << k) - 64'd1);
      end else begin
        case ($urandom_range(0, 6))
          0: b = 63'd0;
          1: b = rand_multiple();
          2: b = 63'd1;
          default: b = rand63();
        endcase
      end
      add_command(make_cmd(o, a, b));
      if (command_queue.size() > 16) begin
        while (command_queue.size() > 4) @(negedge clk);
      end
    end

    while (command_queue.size() > 0 || pending_residues.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("PASS modular_power_and_divide");
    end else begin
      $display("FAIL modular_power_and_divide");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_mulmod.sv
hw/rtl/mpd_datapath.sv
hw/rtl/mpd_ctrl.sv
hw/rtl/modular_power_and_divide.sv
test/modular_power_and_divide_tb.sv
